>>> design/im2c_pkg.sv
// im2c_pkg: shared types and constants of the im2col address generator
// configuration register map, register file image and walk item fields
// no dependencies
package im2c_pkg;

	localparam int H_W     = 12;
	localparam int W_W     = 12;
	localparam int C_W     = 10;
	localparam int N_W     = 8;
	localparam int K_W     = 4;
	localparam int S_W     = 4;
	localparam int CFG_W   = 12;
	localparam int IDX_W   = 3;
	localparam int PLANE_W = H_W + W_W;
	localparam int OUT_W   = 32;

	typedef enum logic [IDX_W-1:0] {
		REG_IMAGE_HEIGHT  = 3'd0,
		REG_IMAGE_WIDTH   = 3'd1,
		REG_CHANNEL_COUNT = 3'd2,
		REG_BATCH_COUNT   = 3'd3,
		REG_KERNEL_HEIGHT = 3'd4,
		REG_KERNEL_WIDTH  = 3'd5,
		REG_STRIDE_STEP   = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [H_W-1:0] image_height;
		logic [W_W-1:0] image_width;
		logic [C_W-1:0] channel_count;
		logic [N_W-1:0] batch_count;
		logic [K_W-1:0] kernel_height;
		logic [K_W-1:0] kernel_width;
		logic [S_W-1:0] stride_step;
	} cfg_t;

	// fixed-width part of one walk position handed to the address pipeline
	typedef struct packed {
		logic [K_W-1:0] kern_row;
		logic [K_W-1:0] kern_col;
		logic [C_W-1:0] chan_idx;
		logic [N_W-1:0] image_idx;
		logic           pair_ok;
		logic           is_last;
	} walk_t;

	// a stride of zero behaves as one
	function automatic logic [S_W-1:0] eff_stride(input logic [S_W-1:0] s);
		eff_stride = (s == '0) ? S_W'(1) : s;
	endfunction

endpackage

>>> design/im2c_cfg.sv
// im2c_cfg: configuration register file of the im2col address generator
// depends on im2c_pkg for the register map and cfg_t
module im2c_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [im2c_pkg::IDX_W-1:0]  cfg_addr,
	input  logic [im2c_pkg::CFG_W-1:0]  cfg_data,
	output im2c_pkg::cfg_t              cfg
);

	im2c_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_height  <= 12'd1;
			cfg_q.image_width   <= 12'd1;
			cfg_q.channel_count <= 10'd1;
			cfg_q.batch_count   <= 8'd1;
			cfg_q.kernel_height <= 4'd1;
			cfg_q.kernel_width  <= 4'd1;
			cfg_q.stride_step   <= 4'd1;
		end else if (cfg_wr_en) begin
			case (im2c_pkg::reg_idx_t'(cfg_addr))
				im2c_pkg::REG_IMAGE_HEIGHT:  cfg_q.image_height  <= cfg_data[11:0];
				im2c_pkg::REG_IMAGE_WIDTH:   cfg_q.image_width   <= cfg_data[11:0];
				im2c_pkg::REG_CHANNEL_COUNT: cfg_q.channel_count <= cfg_data[9:0];
				im2c_pkg::REG_BATCH_COUNT:   cfg_q.batch_count   <= cfg_data[7:0];
				im2c_pkg::REG_KERNEL_HEIGHT: cfg_q.kernel_height <= cfg_data[3:0];
				im2c_pkg::REG_KERNEL_WIDTH:  cfg_q.kernel_width  <= cfg_data[3:0];
				im2c_pkg::REG_STRIDE_STEP:   cfg_q.stride_step   <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> design/im2c_walk.sv
// im2c_walk: nested loop counters and destination count of the im2col walk
// depends on im2c_pkg for cfg_t and walk_t
module im2c_walk #(
	parameter int ADDR_BITS = 32,
	parameter int DIM_BITS  = 12
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  im2c_pkg::cfg_t       cfg,
	input  logic                 accept,
	input  logic                 restart,
	output im2c_pkg::walk_t      pos,
	output logic [DIM_BITS-1:0]  out_row,
	output logic [DIM_BITS-1:0]  out_col,
	output logic [ADDR_BITS-1:0] dest
);

	localparam int PW = DIM_BITS + 5;
	localparam int CW = (PW > im2c_pkg::H_W) ? PW : im2c_pkg::H_W;

	logic [DIM_BITS-1:0]  out_col_q, out_row_q, out_col_c, out_row_c, out_col_n, out_row_n;
	logic [7:0]           image_q, image_c, image_n;
	logic [9:0]           chan_q, chan_c, chan_n;
	logic [3:0]           kcol_q, kcol_c, kcol_n, krow_q, krow_c, krow_n;
	logic [ADDR_BITS-1:0] dest_q, dest_c, dest_n;

	logic [3:0]          stride;
	logic                pair_ok;
	logic [11:0]         row_span, col_span;
	logic [DIM_BITS:0]   row_inc, col_inc;
	logic [PW-1:0]       row_prod, col_prod;
	logic                krow_lim, kcol_lim, chan_lim, image_lim, row_lim, col_lim;
	logic                row_wrap, col_wrap;
	logic                w0, w1, w2, w3, w4, w5;
	logic                is_last;

	// restart clears the walk before the step is taken
	always_comb begin
		out_col_c = restart ? '0 : out_col_q;
		out_row_c = restart ? '0 : out_row_q;
		image_c   = restart ? '0 : image_q;
		chan_c    = restart ? '0 : chan_q;
		kcol_c    = restart ? '0 : kcol_q;
		krow_c    = restart ? '0 : krow_q;
		dest_c    = restart ? '0 : dest_q;
	end

	assign stride  = im2c_pkg::eff_stride(cfg.stride_step);
	assign pair_ok = (cfg.image_height != '0) && (cfg.image_width != '0) &&
		(cfg.channel_count != '0) && (cfg.batch_count != '0) &&
		(cfg.kernel_height != '0) && (cfg.kernel_width != '0) &&
		(12'(cfg.kernel_height) <= cfg.image_height) &&
		(12'(cfg.kernel_width) <= cfg.image_width);

	// (ctr + 1) >= (span / s + 1) is the same as (ctr + 1) * s > span
	assign row_span = cfg.image_height - 12'(cfg.kernel_height);
	assign col_span = cfg.image_width - 12'(cfg.kernel_width);
	assign row_inc  = {1'b0, out_row_c} + 1'b1;
	assign col_inc  = {1'b0, out_col_c} + 1'b1;
	assign row_prod = PW'(row_inc) * PW'(stride);
	assign col_prod = PW'(col_inc) * PW'(stride);

	assign krow_lim  = ({1'b0, krow_c} + 5'd1) >= {1'b0, cfg.kernel_height};
	assign kcol_lim  = ({1'b0, kcol_c} + 5'd1) >= {1'b0, cfg.kernel_width};
	assign chan_lim  = ({1'b0, chan_c} + 11'd1) >= {1'b0, cfg.channel_count};
	assign image_lim = ({1'b0, image_c} + 9'd1) >= {1'b0, cfg.batch_count};
	assign row_lim   = CW'(row_prod) > CW'(row_span);
	assign col_lim   = CW'(col_prod) > CW'(col_span);
	// a full window counter also wraps on overflow of its own width
	assign row_wrap  = row_lim || (&out_row_c);
	assign col_wrap  = col_lim || (&out_col_c);

	assign is_last = krow_lim && kcol_lim && chan_lim && image_lim && row_lim && col_lim;

	assign w0 = krow_lim;
	assign w1 = w0 && kcol_lim;
	assign w2 = w1 && chan_lim;
	assign w3 = w2 && image_lim;
	assign w4 = w3 && row_wrap;
	assign w5 = w4 && col_wrap;

	always_comb begin
		krow_n    = krow_lim ? '0 : krow_c + 4'd1;
		kcol_n    = w0 ? (kcol_lim ? '0 : kcol_c + 4'd1) : kcol_c;
		chan_n    = w1 ? (chan_lim ? '0 : chan_c + 10'd1) : chan_c;
		image_n   = w2 ? (image_lim ? '0 : image_c + 8'd1) : image_c;
		out_row_n = w3 ? (row_wrap ? '0 : out_row_c + 1'b1) : out_row_c;
		out_col_n = w4 ? (col_wrap ? '0 : out_col_c + 1'b1) : out_col_c;
		dest_n    = w5 ? '0 : dest_c + 1'b1;
		if (is_last) begin
			krow_n    = '0;
			kcol_n    = '0;
			chan_n    = '0;
			image_n   = '0;
			out_row_n = '0;
			out_col_n = '0;
			dest_n    = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_col_q <= '0;
			out_row_q <= '0;
			image_q   <= '0;
			chan_q    <= '0;
			kcol_q    <= '0;
			krow_q    <= '0;
			dest_q    <= '0;
		end else if (accept) begin
			if (pair_ok) begin
				out_col_q <= out_col_n;
				out_row_q <= out_row_n;
				image_q   <= image_n;
				chan_q    <= chan_n;
				kcol_q    <= kcol_n;
				krow_q    <= krow_n;
				dest_q    <= dest_n;
			end else begin
				out_col_q <= out_col_c;
				out_row_q <= out_row_c;
				image_q   <= image_c;
				chan_q    <= chan_c;
				kcol_q    <= kcol_c;
				krow_q    <= krow_c;
				dest_q    <= dest_c;
			end
		end
	end

	assign pos.kern_row  = krow_c;
	assign pos.kern_col  = kcol_c;
	assign pos.chan_idx  = chan_c;
	assign pos.image_idx = image_c;
	assign pos.pair_ok   = pair_ok;
	assign pos.is_last   = is_last;
	assign out_row       = out_row_c;
	assign out_col       = out_col_c;
	assign dest          = dest_c;

`ifndef ASSERT_OFF
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && pair_ok && is_last |=> (krow_q == '0 && kcol_q == '0 && chan_q == '0 &&
			image_q == '0 && out_row_q == '0 && out_col_q == '0 && dest_q == '0))
		else $error("walk not cleared after final pair");
	a_dest_step: assert property (@(posedge clk) disable iff (!arst_n)
		accept && pair_ok && !is_last && !w5 |=> dest_q == $past(dest_c) + 1'b1)
		else $error("destination count did not step by one");
	a_hold_no_pair: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !pair_ok && !restart |=> $stable(dest_q) && $stable(krow_q))
		else $error("walk advanced without a pair");
`endif

endmodule

>>> design/im2c_pipe.sv
// im2c_pipe: five-stage address pipeline with per-stage valid and bubble collapse
// forms the source index from a walk position; depends on im2c_pkg
module im2c_pipe #(
	parameter int ADDR_BITS = 32,
	parameter int DIM_BITS  = 12
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  im2c_pkg::cfg_t                cfg,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  im2c_pkg::walk_t               pos,
	input  logic [DIM_BITS-1:0]           out_row,
	input  logic [DIM_BITS-1:0]           out_col,
	input  logic [ADDR_BITS-1:0]          dest,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [im2c_pkg::OUT_W-1:0]    src_index,
	output logic [im2c_pkg::OUT_W-1:0]    dst_index,
	output logic                          valid_res,
	output logic                          last
);

	localparam int PLANE_W = im2c_pkg::PLANE_W;
	localparam int C_W     = im2c_pkg::C_W;
	localparam int N_W     = im2c_pkg::N_W;
	localparam int OUT_W   = im2c_pkg::OUT_W;
	localparam int RW      = DIM_BITS + 5;
	localparam int ISZ_W   = PLANE_W + C_W;
	localparam int CT_W    = RW + im2c_pkg::H_W;
	localparam int IT_W    = ADDR_BITS + N_W;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic en1, en2, en3, en4, en5;

	// stage 1: captured walk position
	im2c_pkg::walk_t      pos_s1;
	logic [DIM_BITS-1:0]  row_s1, col_s1;
	logic [ADDR_BITS-1:0] dest_s1;

	// stage 2: plane size, window row and column positions
	logic [PLANE_W-1:0]   plane_s2;
	logic [RW-1:0]        row_part_s2, colpos_s2;
	logic [C_W-1:0]       chan_s2;
	logic [N_W-1:0]       image_s2;
	logic [ADDR_BITS-1:0] dest_s2;
	logic                 ok_s2, last_s2;

	// stage 3: image size, channel and column terms
	logic [ADDR_BITS-1:0] image_size_s3, chan_term_s3, col_term_s3;
	logic [RW-1:0]        row_part_s3;
	logic [N_W-1:0]       image_s3;
	logic [ADDR_BITS-1:0] dest_s3;
	logic                 ok_s3, last_s3;

	// stage 4: image term and partial sum
	logic [ADDR_BITS-1:0] img_term_s4, part_s4, dest_s4;
	logic                 ok_s4, last_s4;

	// stage 5: result register
	logic [ADDR_BITS-1:0] src_s5, dest_s5;
	logic                 ok_s5, last_s5;

	logic [im2c_pkg::S_W-1:0] stride;
	logic [ISZ_W-1:0]         isz_full, cterm_full;
	logic [CT_W-1:0]          colterm_full;
	logic [IT_W-1:0]          iterm_full;

	assign en5 = !v_s5 || out_ready;
	assign en4 = !v_s4 || en5;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign in_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
		end
	end

	assign stride       = im2c_pkg::eff_stride(cfg.stride_step);
	assign isz_full     = ISZ_W'(plane_s2) * ISZ_W'(cfg.channel_count);
	assign cterm_full   = ISZ_W'(plane_s2) * ISZ_W'(chan_s2);
	assign colterm_full = CT_W'(colpos_s2) * CT_W'(cfg.image_height);
	assign iterm_full   = IT_W'(image_s3) * IT_W'(image_size_s3);

	always_ff @(posedge clk) begin
		if (en1) begin
			pos_s1  <= pos;
			row_s1  <= out_row;
			col_s1  <= out_col;
			dest_s1 <= dest;
		end
		if (en2) begin
			plane_s2    <= PLANE_W'(cfg.image_height) * PLANE_W'(cfg.image_width);
			row_part_s2 <= RW'(row_s1) * RW'(stride) + RW'(pos_s1.kern_row);
			colpos_s2   <= RW'(col_s1) * RW'(stride) + RW'(pos_s1.kern_col);
			chan_s2     <= pos_s1.chan_idx;
			image_s2    <= pos_s1.image_idx;
			dest_s2     <= dest_s1;
			ok_s2       <= pos_s1.pair_ok;
			last_s2     <= pos_s1.is_last;
		end
		if (en3) begin
			image_size_s3 <= ADDR_BITS'(isz_full);
			chan_term_s3  <= ADDR_BITS'(cterm_full);
			col_term_s3   <= ADDR_BITS'(colterm_full);
			row_part_s3   <= row_part_s2;
			image_s3      <= image_s2;
			dest_s3       <= dest_s2;
			ok_s3         <= ok_s2;
			last_s3       <= last_s2;
		end
		if (en4) begin
			img_term_s4 <= ADDR_BITS'(iterm_full);
			part_s4     <= ADDR_BITS'(row_part_s3) + chan_term_s3 + col_term_s3;
			dest_s4     <= dest_s3;
			ok_s4       <= ok_s3;
			last_s4     <= last_s3;
		end
		if (en5) begin
			// no pair: every field of the result reads zero
			src_s5  <= ok_s4 ? part_s4 + img_term_s4 : '0;
			dest_s5 <= ok_s4 ? dest_s4 : '0;
			ok_s5   <= ok_s4;
			last_s5 <= ok_s4 && last_s4;
		end
	end

	assign out_valid = v_s5;
	assign src_index = OUT_W'(src_s5);
	assign dst_index = OUT_W'(dest_s5);
	assign valid_res = ok_s5;
	assign last      = last_s5;

`ifndef ASSERT_OFF
	a_bubble_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(!v_s1 || !v_s2 || !v_s3 || !v_s4 || !v_s5) |-> in_ready)
		else $error("input refused while the pipeline holds a bubble");
	a_no_pair_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !valid_res |-> (src_index == '0 && dst_index == '0 && !last))
		else $error("result without a pair carries non-zero fields");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(src_index) &&
			$stable(dst_index) && $stable(valid_res) && $stable(last))
		else $error("waiting result changed before its transfer");
`endif

endmodule

>>> design/im2col_address_generator_top.sv
// im2col_address_generator_top: top level of the im2col address generator
// instantiates im2c_cfg, im2c_walk and im2c_pipe; depends on im2c_pkg
//
// One result per input transfer: each accepted transfer (restart = 1 starts the walk over)
// yields the (src_index, dst_index) pair of the next im2col position over a column-major
// [H,W,C,N] tensor, in loop order output column, output row, image, channel, kernel
// column, kernel row. A new transfer is taken every cycle while out_ready is high, so
// the sustained rate is one pair per clock. The address pipeline has five register stages:
// the plane size, window row and column positions are formed in stage two, the image size,
// channel and column products in stage three, the image product and partial sum in stage
// four and the final sum in the result register. A result passes stages one to five in
// order before it is on the outputs. The loop counters advance in the cycle of the input
// transfer, so the walk never waits on the address arithmetic. The output register and
// the per-stage valid bits let input transfers continue while a result waits, until all
// five stages are full. When the kernel exceeds the image, or a size register is zero,
// the result has valid_res = 0 with every other field zero and the walk holds. The user
// must write registers through cfg_wr_en / cfg_addr / cfg_data only while no result is
// outstanding; the block itself does not enforce this. There is no clearing pass after reset.
module im2col_address_generator_top #(
	parameter int ADDR_BITS = 32,
	parameter int DIM_BITS  = 12
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration write port
	input  logic                          cfg_wr_en,
	input  logic [im2c_pkg::IDX_W-1:0]    cfg_addr,
	input  logic [im2c_pkg::CFG_W-1:0]    cfg_data,
	// input channel
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          restart,
	// result channel
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [im2c_pkg::OUT_W-1:0]    src_index,
	output logic [im2c_pkg::OUT_W-1:0]    dst_index,
	output logic                          valid_res,
	output logic                          last
);

	im2c_pkg::cfg_t       cfg;
	im2c_pkg::walk_t      pos;
	logic [DIM_BITS-1:0]  out_row, out_col;
	logic [ADDR_BITS-1:0] dest;
	logic                 accept;

	// an input transfer both steps the walk and enters the pipeline
	assign accept = in_valid && in_ready;

	im2c_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_addr  (cfg_addr),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// loop counters and running destination count
	im2c_walk #(
		.ADDR_BITS (ADDR_BITS),
		.DIM_BITS  (DIM_BITS)
	) u_walk (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.accept  (accept),
		.restart (restart),
		.pos     (pos),
		.out_row (out_row),
		.out_col (out_col),
		.dest    (dest)
	);

	// source index arithmetic and result register
	im2c_pipe #(
		.ADDR_BITS (ADDR_BITS),
		.DIM_BITS  (DIM_BITS)
	) u_pipe (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.pos       (pos),
		.out_row   (out_row),
		.out_col   (out_col),
		.dest      (dest),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.src_index (src_index),
		.dst_index (dst_index),
		.valid_res (valid_res),
		.last      (last)
	);

endmodule
